// ===== hdl/smf_pkg.sv =====
// Shared constants and types for the MIDI file track parser.
`timescale 1ns / 1ps

package smf_pkg;

  localparam logic [31:0] TAG_HEAD  = 32'h4D54_6864;
  localparam logic [31:0] TAG_TRACK = 32'h4D54_726B;

  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_CHANNEL = 3'd1;
  localparam logic [2:0] KIND_META    = 3'd2;
  localparam logic [2:0] KIND_PAYLOAD = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;
  localparam logic [2:0] KIND_UNSUPP  = 3'd5;

  localparam logic [7:0] ERR_BAD_TAG     = 8'd1;
  localparam logic [7:0] ERR_HDR_LEN     = 8'd2;
  localparam logic [7:0] ERR_FORMAT2     = 8'd3;
  localparam logic [7:0] ERR_TRACK_ZERO  = 8'd4;
  localparam logic [7:0] ERR_NO_RUNNING  = 8'd5;
  localparam logic [7:0] ERR_PAST_BUDGET = 8'd6;
  localparam logic [7:0] ERR_META_LEN    = 8'd7;

  localparam logic [7:0] STATUS_META = 8'hFF;

  typedef struct packed {
    logic [7:0] data;
    logic       file_start;
  } smf_item_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  kind;
    logic [15:0] track_index;
    logic [31:0] delta_time;
    logic [7:0]  status;
    logic [7:0]  data1;
    logic [7:0]  data2;
    logic [31:0] length;
    logic        last;
    logic [15:0] file_format;
    logic [15:0] track_count;
    logic [15:0] division;
  } smf_result_t;

endpackage

// ===== hdl/smf_in_stage.sv =====
// Input register that holds one byte beat ahead of the parser.
`timescale 1ns / 1ps

module smf_in_stage
  import smf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] byte_in,
  input  logic       file_start,
  input  logic       take,
  output logic       full,
  output smf_item_t  item
);

  assign byte_stall = full && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      item.data       <= byte_in;
      item.file_start <= file_start;
    end
  end

endmodule

// ===== hdl/smf_parse_core.sv =====
// Parser state and the per-byte next-state and result logic.
`timescale 1ns / 1ps

module smf_parse_core
  import smf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  smf_item_t   item,
  output smf_result_t res
);

  typedef enum logic [3:0] {
    PH_HDR, PH_SEEK, PH_LEN, PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2,
    PH_MTYPE, PH_MLEN, PH_MDATA, PH_DONE, PH_ERR
  } phase_t;

  phase_t      phase, phase_next, cur_phase;
  logic [3:0]  fc, fc_next, cur_fc, fc_inc;
  logic [31:0] ws, ws_next, cur_ws, hdr_shift, seek_shift;
  logic [15:0] te, te_next, cur_te;
  logic [15:0] td, td_next, cur_td, td_plus;
  logic [31:0] tbl, tbl_next, cur_tbl, tbl_dec;
  logic [7:0]  rc, rc_next, cur_rc;
  logic        hr, hr_next, cur_hr;
  logic [31:0] delta, delta_next, cur_delta;
  logic [7:0]  fd, fd_next, cur_fd;
  logic [31:0] ml, ml_next, cur_ml, ml_new, ml_dec;
  logic [7:0]  b;
  logic        two_data, fail_en, ev_en, tail_en;
  logic [7:0]  fail_code;

  assign b = item.data;

  assign cur_phase = item.file_start ? PH_HDR : phase;
  assign cur_fc    = item.file_start ? 4'd0   : fc;
  assign cur_ws    = item.file_start ? 32'd0  : ws;
  assign cur_te    = item.file_start ? 16'd0  : te;
  assign cur_td    = item.file_start ? 16'd0  : td;
  assign cur_tbl   = item.file_start ? 32'd0  : tbl;
  assign cur_rc    = item.file_start ? 8'd0   : rc;
  assign cur_hr    = item.file_start ? 1'b0   : hr;
  assign cur_delta = item.file_start ? 32'd0  : delta;
  assign cur_fd    = item.file_start ? 8'd0   : fd;
  assign cur_ml    = item.file_start ? 32'd0  : ml;

  assign fc_inc     = cur_fc + 4'd1;
  assign hdr_shift  = (cur_fc <= 4'd11) ? {cur_ws[23:0], b}
                                        : {cur_ws[31:16], cur_ws[7:0], b};
  assign seek_shift = {cur_ws[23:0], b};
  assign tbl_dec    = cur_tbl - 32'd1;
  assign td_plus    = cur_td + 16'd1;
  assign ml_new     = {cur_ml[24:0], b[6:0]};
  assign ml_dec     = cur_ml - 32'd1;
  assign two_data   = !((cur_rc[7:4] == 4'hC) || (cur_rc[7:4] == 4'hD));

  always_comb begin
    phase_next = cur_phase;
    fc_next    = cur_fc;
    ws_next    = cur_ws;
    te_next    = cur_te;
    td_next    = cur_td;
    tbl_next   = cur_tbl;
    rc_next    = cur_rc;
    hr_next    = cur_hr;
    delta_next = cur_delta;
    fd_next    = cur_fd;
    ml_next    = cur_ml;
    res        = '0;
    res.track_index = cur_td;
    fail_en    = 1'b0;
    fail_code  = 8'd0;
    ev_en      = 1'b0;
    tail_en    = 1'b0;

    unique case (cur_phase)
      PH_HDR: begin
        ws_next = hdr_shift;
        fc_next = fc_inc;
        if (cur_fc == 4'd3 && hdr_shift != TAG_HEAD) begin
          fail_en   = 1'b1;
          fail_code = ERR_BAD_TAG;
        end else if (cur_fc == 4'd7 && hdr_shift != 32'd6) begin
          fail_en   = 1'b1;
          fail_code = ERR_HDR_LEN;
        end else if (cur_fc == 4'd9 && hdr_shift[15:0] == 16'd2) begin
          fail_en   = 1'b1;
          fail_code = ERR_FORMAT2;
        end else if (cur_fc == 4'd11) begin
          te_next = hdr_shift[15:0];
          ws_next = {hdr_shift[31:16], 16'd0};
        end else if (cur_fc == 4'd13) begin
          res.valid       = 1'b1;
          res.kind        = KIND_HEADER;
          res.track_index = 16'd0;
          res.file_format = hdr_shift[31:16];
          res.track_count = cur_te;
          res.division    = hdr_shift[15:0];
          if (cur_te == 16'd0) begin
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_SEEK;
            fc_next    = 4'd0;
            ws_next    = 32'd0;
          end
        end
      end
      PH_SEEK: begin
        ws_next = seek_shift;
        fc_next = fc_inc;
        if (fc_inc >= 4'd4) begin
          fc_next = 4'd0;
          if (seek_shift == TAG_TRACK) begin
            phase_next = PH_LEN;
            ws_next    = 32'd0;
          end
        end
      end
      PH_LEN: begin
        ws_next = seek_shift;
        fc_next = fc_inc;
        if (fc_inc >= 4'd4) begin
          fc_next = 4'd0;
          if (seek_shift == 32'd0) begin
            fail_en   = 1'b1;
            fail_code = ERR_TRACK_ZERO;
          end else begin
            tbl_next   = seek_shift;
            hr_next    = 1'b0;
            rc_next    = 8'd0;
            delta_next = 32'd0;
            phase_next = PH_DELTA;
          end
        end
      end
      PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_MTYPE, PH_MLEN, PH_MDATA: begin
        if (cur_tbl == 32'd0) begin
          fail_en   = 1'b1;
          fail_code = ERR_PAST_BUDGET;
        end else begin
          tbl_next = tbl_dec;
          unique case (cur_phase)
            PH_DELTA: begin
              delta_next = {cur_delta[24:0], b[6:0]};
              if (!b[7]) begin
                phase_next = PH_STATUS;
              end
              tail_en = 1'b1;
            end
            PH_STATUS: begin
              if (b[7]) begin
                if (b == STATUS_META) begin
                  phase_next = PH_MTYPE;
                  tail_en    = 1'b1;
                end else if (b >= 8'hF0) begin
                  hr_next        = 1'b0;
                  res.valid      = 1'b1;
                  res.kind       = KIND_UNSUPP;
                  res.delta_time = cur_delta;
                  res.status     = b;
                  ev_en          = 1'b1;
                end else begin
                  rc_next    = b;
                  hr_next    = 1'b1;
                  phase_next = PH_DATA1;
                  tail_en    = 1'b1;
                end
              end else if (!cur_hr) begin
                fail_en   = 1'b1;
                fail_code = ERR_NO_RUNNING;
              end else if (!two_data) begin
                res.valid      = 1'b1;
                res.kind       = KIND_CHANNEL;
                res.delta_time = cur_delta;
                res.status     = cur_rc;
                res.data1      = b;
                ev_en          = 1'b1;
              end else begin
                fd_next    = b;
                phase_next = PH_DATA2;
                tail_en    = 1'b1;
              end
            end
            PH_DATA1: begin
              if (!two_data) begin
                res.valid      = 1'b1;
                res.kind       = KIND_CHANNEL;
                res.delta_time = cur_delta;
                res.status     = cur_rc;
                res.data1      = b;
                ev_en          = 1'b1;
              end else begin
                fd_next    = b;
                phase_next = PH_DATA2;
                tail_en    = 1'b1;
              end
            end
            PH_DATA2: begin
              res.valid      = 1'b1;
              res.kind       = KIND_CHANNEL;
              res.delta_time = cur_delta;
              res.status     = cur_rc;
              res.data1      = cur_fd;
              res.data2      = b;
              ev_en          = 1'b1;
            end
            PH_MTYPE: begin
              fd_next    = b;
              ml_next    = 32'd0;
              phase_next = PH_MLEN;
              tail_en    = 1'b1;
            end
            PH_MLEN: begin
              ml_next = ml_new;
              if (b[7]) begin
                tail_en = 1'b1;
              end else if (ml_new > tbl_dec) begin
                fail_en   = 1'b1;
                fail_code = ERR_META_LEN;
              end else begin
                res.valid      = 1'b1;
                res.kind       = KIND_META;
                res.delta_time = cur_delta;
                res.status     = STATUS_META;
                res.data1      = cur_fd;
                res.length     = ml_new;
                res.last       = (ml_new == 32'd0);
                if (ml_new == 32'd0) begin
                  ev_en = 1'b1;
                end else begin
                  phase_next = PH_MDATA;
                end
              end
            end
            PH_MDATA: begin
              ml_next        = ml_dec;
              res.valid      = 1'b1;
              res.kind       = KIND_PAYLOAD;
              res.delta_time = cur_delta;
              res.status     = STATUS_META;
              res.data1      = b;
              res.last       = (ml_dec == 32'd0);
              ev_en          = (ml_dec == 32'd0);
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase

    if (tail_en && tbl_dec == 32'd0) begin
      fail_en   = 1'b1;
      fail_code = ERR_PAST_BUDGET;
    end

    if (ev_en) begin
      if (tbl_dec == 32'd0) begin
        td_next = td_plus;
        if (td_plus == cur_te) begin
          phase_next = PH_DONE;
        end else begin
          phase_next = PH_SEEK;
          fc_next    = 4'd0;
          ws_next    = 32'd0;
        end
      end else begin
        phase_next = PH_DELTA;
        delta_next = 32'd0;
      end
    end

    if (fail_en) begin
      res             = '0;
      res.valid       = 1'b1;
      res.kind        = KIND_ERROR;
      res.track_index = cur_td;
      res.data1       = fail_code;
      phase_next      = PH_ERR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HDR;
      fc    <= 4'd0;
      ws    <= 32'd0;
      te    <= 16'd0;
      td    <= 16'd0;
      tbl   <= 32'd0;
      rc    <= 8'd0;
      hr    <= 1'b0;
      delta <= 32'd0;
      fd    <= 8'd0;
      ml    <= 32'd0;
    end else if (adv) begin
      phase <= phase_next;
      fc    <= fc_next;
      ws    <= ws_next;
      te    <= te_next;
      td    <= td_next;
      tbl   <= tbl_next;
      rc    <= rc_next;
      hr    <= hr_next;
      delta <= delta_next;
      fd    <= fd_next;
      ml    <= ml_next;
    end
  end

endmodule

// ===== hdl/midi_file_track_parser.sv =====
// Top level of the MIDI file track parser with its result register.
//
// The block takes a Standard MIDI File one byte beat at a time on the byte
// channel (byte_valid, byte_stall, byte_in, file_start) and gives at most one
// result beat per byte on the event channel (event_valid, event_stall and the
// result fields). A byte with file_start high restarts the parser and is taken
// as the first header byte. The header, channel events, meta headers, meta
// payload bytes, errors and unsupported codes each come out as one beat.
// A byte passes through an input register and then a result register on its
// way to the event channel.
// One byte is taken in every cycle while the event channel keeps up; the rate
// is set by the single parser state update per byte.
// Bytes that cause no result leave no beat on the event channel.
// While event_stall holds a result, the input register fills and byte_stall
// rises; nothing is lost or repeated.
// Reset clears the parser state and the valid flags of both channel registers
// and puts the parser in wait for a file header.
`timescale 1ns / 1ps

module midi_file_track_parser
  import smf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  byte_in,
  input  logic        file_start,
  output logic        event_valid,
  input  logic        event_stall,
  output logic [2:0]  kind,
  output logic [15:0] track_index,
  output logic [31:0] delta_time,
  output logic [7:0]  status,
  output logic [7:0]  data1,
  output logic [7:0]  data2,
  output logic [31:0] length,
  output logic        last,
  output logic [15:0] file_format,
  output logic [15:0] track_count,
  output logic [15:0] division
);

  smf_item_t   item;
  smf_result_t res;
  logic        full;
  logic        adv;

  assign adv = full && (!event_valid || !event_stall);

  smf_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_in    (byte_in),
    .file_start (file_start),
    .take       (adv),
    .full       (full),
    .item       (item)
  );

  smf_parse_core u_parse_core (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .item (item),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (adv) begin
      event_valid <= res.valid;
    end else if (!event_stall) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind        <= res.kind;
      track_index <= res.track_index;
      delta_time  <= res.delta_time;
      status      <= res.status;
      data1       <= res.data1;
      data2       <= res.data2;
      length      <= res.length;
      last        <= res.last;
      file_format <= res.file_format;
      track_count <= res.track_count;
      division    <= res.division;
    end
  end

endmodule
